/* rtl/mulliken_population_charges_top_assert.svh */
// Assertion macros for the Mulliken population block.
`ifndef MULLIKEN_POPULATION_CHARGES_TOP_ASSERT_SVH
`define MULLIKEN_POPULATION_CHARGES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off during reset.
`define MPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mpc assertion failed");
// Clocked implication check.
`define MPC_ASSERT_IMP(lbl, ante, cons) \
    `MPC_ASSERT(lbl, (ante) |-> (cons))
`else
`define MPC_ASSERT(lbl, prop)
`define MPC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

/* rtl/mpc_pkg.sv */
// Package: constants, types and arithmetic helpers for the Mulliken population block.
package mpc_pkg;

    localparam int MAX_ORBITALS = 32;
    localparam int MAX_CENTERS  = 16;
    localparam int TRI_DEPTH    = MAX_ORBITALS * (MAX_ORBITALS + 1) / 2;
    localparam int ORB_W        = $clog2(MAX_ORBITALS);
    localparam int CTR_W        = $clog2(MAX_CENTERS);
    localparam int ADDR_W       = $clog2(TRI_DEPTH);
    localparam int SUM_W        = 70;
    localparam int RES_W        = 48;

    typedef enum logic [2:0] {
        KIND_ALPHA  = 3'd0,
        KIND_BETA   = 3'd1,
        KIND_OVLP   = 3'd2,
        KIND_ORBCTR = 3'd3,
        KIND_CHARGE = 3'd4,
        KIND_RUN    = 3'd5
    } kind_t;

    typedef enum logic {
        REG_NUM_ORBITALS = 1'b0,
        REG_NUM_CENTERS  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND,
        ST_SUB_A,
        ST_SUB_B,
        ST_EMIT_POP,
        ST_EMIT_CHG
    } state_t;

    typedef struct packed {
        logic             load;
        logic             start;
        logic             issue;
        logic             round;
        logic             sub_a;
        logic             sub_b;
        logic             emit_pop;
        logic             emit_chg;
        logic             last;
        logic [ORB_W-1:0] orb;
        logic [ORB_W-1:0] col;
        logic [CTR_W-1:0] ctr;
        logic [CTR_W:0]   num_ctr;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } status_t;

    // Packed lower-triangle address of element (r, c), either order.
    function automatic logic [ADDR_W-1:0] tri_addr(input logic [ORB_W-1:0] r,
                                                   input logic [ORB_W-1:0] c);
        logic [ORB_W-1:0]  hi;
        logic [ORB_W-1:0]  lo;
        logic [2*ORB_W:0]  prod;
        hi   = (r >= c) ? r : c;
        lo   = (r >= c) ? c : r;
        prod = ({1'b0, hi} * ({1'b0, hi} + 1'b1));
        tri_addr = ADDR_W'((prod >> 1) + lo);
    endfunction

    // Saturating 48-bit subtract.
    function automatic logic signed [RES_W-1:0] sat_sub(input logic signed [RES_W-1:0] a,
                                                        input logic signed [RES_W-1:0] b);
        logic signed [RES_W:0] d;
        d = {a[RES_W-1], a} - {b[RES_W-1], b};
        if (d[RES_W] != d[RES_W-1]) begin
            sat_sub = d[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
        end else begin
            sat_sub = d[RES_W-1:0];
        end
    endfunction

endpackage

/* rtl/mulliken_population_charges_top.sv */
// Top level of the Mulliken population block: controller plus datapath.
// Load items (alpha, beta, overlap triangle elements, orbital owners, center charges)
// are taken one per cycle. A run item then computes, for each orbital i of n in use,
// alpha and beta populations sum_k P[i][k]*S[k][i] on two multipliers sharing one
// read port per store. Per orbital: n reads, drain, rounding and charge update; the run
// emits n population results followed by one net charge per center (last on the final).
// No input is taken while a run is in progress.
module mulliken_population_charges_top
    import mpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_kind,
    input  logic [9:0]               s_index,
    input  logic signed [31:0]       s_value,
    input  logic [3:0]               s_center_index,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [5:0]               cfg_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic [4:0]               m_item_index,
    output logic signed [RES_W-1:0]  m_alpha_value,
    output logic signed [RES_W-1:0]  m_beta_value,
    output logic                     m_last
);

    cmd_t    cmd;
    status_t status;

    mpc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    mpc_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_kind),
        .s_index        (s_index),
        .s_value        (s_value),
        .s_center_index (s_center_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_item_index   (m_item_index),
        .m_alpha_value  (m_alpha_value),
        .m_beta_value   (m_beta_value),
        .m_last         (m_last)
    );

endmodule

/* rtl/mpc_ctrl.sv */
// Controller: run sequencer, configuration registers and loop counters.
module mpc_ctrl
    import mpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    input  status_t     status,
    output cmd_t        cmd
);

    state_t           state_reg, state_next;
    logic [ORB_W-1:0] orb_reg, orb_next;
    logic [ORB_W-1:0] col_reg, col_next;
    logic [CTR_W-1:0] ctr_reg, ctr_next;
    logic [5:0]       norb_reg;
    logic [4:0]       nctr_reg;
    logic [ORB_W:0]   n_eff;
    logic [CTR_W:0]   c_eff;
    logic [ORB_W-1:0] last_orb;
    logic [CTR_W-1:0] last_ctr;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // Clamp counts into their legal ranges.
    always_comb begin
        if (norb_reg == 6'd0) begin
            n_eff = (ORB_W+1)'(1);
        end else if (32'(norb_reg) > MAX_ORBITALS) begin
            n_eff = (ORB_W+1)'(MAX_ORBITALS);
        end else begin
            n_eff = (ORB_W+1)'(norb_reg);
        end
        if (nctr_reg == 5'd0) begin
            c_eff = (CTR_W+1)'(1);
        end else if (32'(nctr_reg) > MAX_CENTERS) begin
            c_eff = (CTR_W+1)'(MAX_CENTERS);
        end else begin
            c_eff = (CTR_W+1)'(nctr_reg);
        end
    end

    assign last_orb = ORB_W'(n_eff - 1'b1);
    assign last_ctr = CTR_W'(c_eff - 1'b1);

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norb_reg <= 6'd32;
            nctr_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_NUM_ORBITALS: norb_reg <= cfg_data;
                REG_NUM_CENTERS:  nctr_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            orb_reg   <= '0;
            col_reg   <= '0;
            ctr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            orb_reg   <= orb_next;
            col_reg   <= col_next;
            ctr_reg   <= ctr_next;
        end
    end

    // Sequence the run.
    always_comb begin
        state_next   = state_reg;
        orb_next     = orb_reg;
        col_next     = col_reg;
        ctr_next     = ctr_reg;
        cmd          = '0;
        cmd.load     = accept;
        cmd.orb      = orb_reg;
        cmd.col      = col_reg;
        cmd.ctr      = ctr_reg;
        cmd.num_ctr  = c_eff;
        cmd.last     = (ctr_reg == last_ctr);
        case (state_reg)
            ST_IDLE: begin
                if (accept && kind_t'(s_kind) == KIND_RUN) begin
                    cmd.start  = 1'b1;
                    orb_next   = '0;
                    col_next   = '0;
                    ctr_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (col_reg == last_orb) begin
                    col_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_SUB_A;
            end
            ST_SUB_A: begin
                cmd.sub_a  = 1'b1;
                state_next = ST_SUB_B;
            end
            ST_SUB_B: begin
                cmd.sub_b  = 1'b1;
                state_next = ST_EMIT_POP;
            end
            ST_EMIT_POP: begin
                if (status.out_free) begin
                    cmd.emit_pop = 1'b1;
                    if (orb_reg == last_orb) begin
                        state_next = ST_EMIT_CHG;
                    end else begin
                        orb_next   = orb_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_EMIT_CHG: begin
                if (status.out_free) begin
                    cmd.emit_chg = 1'b1;
                    if (ctr_reg == last_ctr) begin
                        state_next = ST_IDLE;
                    end else begin
                        ctr_next = ctr_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/mpc_datapath.sv */
// Datapath: stores, multiply-accumulate pipeline, center charges and result register.
module mpc_datapath
    import mpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [2:0]               s_kind,
    input  logic [9:0]               s_index,
    input  logic signed [31:0]       s_value,
    input  logic [3:0]               s_center_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic [4:0]               m_item_index,
    output logic signed [RES_W-1:0]  m_alpha_value,
    output logic signed [RES_W-1:0]  m_beta_value,
    output logic                     m_last
);

`include "mulliken_population_charges_top_assert.svh"

    logic signed [31:0]      mem_a [TRI_DEPTH];
    logic signed [31:0]      mem_b [TRI_DEPTH];
    logic signed [31:0]      mem_s [TRI_DEPTH];
    logic [CTR_W-1:0]        orb_ctr_reg [MAX_ORBITALS];
    logic signed [31:0]      charge_reg [MAX_CENTERS];
    logic signed [RES_W-1:0] acc_reg [MAX_CENTERS];

    logic signed [31:0]      rd_a_reg, rd_b_reg, rd_s_reg;
    logic signed [63:0]      prod_a_reg, prod_b_reg;
    logic signed [SUM_W-1:0] sum_a_reg, sum_b_reg;
    logic signed [SUM_W-1:0] rnd_a, rnd_b;
    logic signed [RES_W-1:0] pa_reg, pb_reg;
    logic [CTR_W-1:0]        owner_reg;
    logic                    v1_reg, v2_reg, m_valid_reg;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    owned;
    kind_t                   kind;

    assign kind    = kind_t'(s_kind);
    assign rd_addr = tri_addr(cmd.orb, cmd.col);
    assign owned   = ({1'b0, owner_reg} < cmd.num_ctr);

    // Write the matrix stores on load, read them on issue.
    always_ff @(posedge aclk) begin
        if (cmd.load && 32'(s_index) < TRI_DEPTH) begin
            if (kind == KIND_ALPHA) mem_a[ADDR_W'(s_index)] <= s_value;
            if (kind == KIND_BETA)  mem_b[ADDR_W'(s_index)] <= s_value;
            if (kind == KIND_OVLP)  mem_s[ADDR_W'(s_index)] <= s_value;
        end
        if (cmd.issue) begin
            rd_a_reg <= mem_a[rd_addr];
            rd_b_reg <= mem_b[rd_addr];
            rd_s_reg <= mem_s[rd_addr];
        end
    end

    // Load orbital owners and center charges.
    always_ff @(posedge aclk) begin
        if (cmd.load && kind == KIND_ORBCTR && 32'(s_index) < MAX_ORBITALS) begin
            orb_ctr_reg[ORB_W'(s_index)] <= s_center_index;
        end
        if (cmd.load && kind == KIND_CHARGE && 32'(s_index) < MAX_CENTERS) begin
            charge_reg[CTR_W'(s_index)] <= s_value;
        end
    end

    // Advance the pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // Multiply, then accumulate exactly.
    always_ff @(posedge aclk) begin
        prod_a_reg <= rd_a_reg * rd_s_reg;
        prod_b_reg <= rd_b_reg * rd_s_reg;
        if (cmd.start || cmd.round) begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else if (v2_reg) begin
            sum_a_reg <= sum_a_reg + SUM_W'(prod_a_reg);
            sum_b_reg <= sum_b_reg + SUM_W'(prod_b_reg);
        end
    end

    // Round to nearest, ties up; the sum always fits 48 bits after the shift.
    assign rnd_a = sum_a_reg + SUM_W'(1 << 23);
    assign rnd_b = sum_b_reg + SUM_W'(1 << 23);

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            pa_reg    <= RES_W'(rnd_a >>> 24);
            pb_reg    <= RES_W'(rnd_b >>> 24);
            owner_reg <= orb_ctr_reg[cmd.orb];
        end
    end

    // Seed and update the per-center net charges.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int j = 0; j < MAX_CENTERS; j++) begin
                acc_reg[j] <= RES_W'(charge_reg[j]);
            end
        end else if (cmd.sub_a && owned) begin
            acc_reg[owner_reg] <= sat_sub(acc_reg[owner_reg], pa_reg);
        end else if (cmd.sub_b && owned) begin
            acc_reg[owner_reg] <= sat_sub(acc_reg[owner_reg], pb_reg);
        end
    end

    // Hold the result register until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_pop || cmd.emit_chg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pop) begin
            m_result_kind <= 1'b0;
            m_item_index  <= 5'(cmd.orb);
            m_alpha_value <= pa_reg;
            m_beta_value  <= pb_reg;
            m_last        <= 1'b0;
        end else if (cmd.emit_chg) begin
            m_result_kind <= 1'b1;
            m_item_index  <= 5'(cmd.ctr);
            m_alpha_value <= acc_reg[cmd.ctr];
            m_beta_value  <= '0;
            m_last        <= cmd.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.busy     = v1_reg || v2_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    `MPC_ASSERT_IMP(a_round_after_drain, cmd.round, !v1_reg && !v2_reg)
    `MPC_ASSERT_IMP(a_emit_loads_output, cmd.emit_pop || cmd.emit_chg, ##1 m_valid)
    `MPC_ASSERT_IMP(a_last_is_charge, m_valid && m_last, m_result_kind)
    `MPC_ASSERT_IMP(a_no_emit_over_full, m_valid && !m_ready, !(cmd.emit_pop || cmd.emit_chg))

endmodule

/* test/mpc_checker.sv */
// Checker for the Mulliken population block: predicts results and compares them.
`timescale 1ns / 100ps

module mpc_checker
    import mpc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [2:0]              s_kind,
    input  logic [9:0]              s_index,
    input  logic signed [31:0]      s_value,
    input  logic [3:0]              s_center_index,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [5:0]              cfg_data,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    m_result_kind,
    input  logic [4:0]              m_item_index,
    input  logic signed [RES_W-1:0] m_alpha_value,
    input  logic signed [RES_W-1:0] m_beta_value,
    input  logic                    m_last,
    output int                      fail_count,
    output int                      pending
);

    typedef struct {
        logic                    rkind;
        logic [4:0]              idx;
        logic signed [RES_W-1:0] a;
        logic signed [RES_W-1:0] b;
        logic                    last;
    } pop_result_t;

    logic signed [31:0] dens_a [TRI_DEPTH];
    logic signed [31:0] dens_b [TRI_DEPTH];
    logic signed [31:0] ovlp   [TRI_DEPTH];
    logic [3:0]         owner  [MAX_ORBITALS];
    logic signed [31:0] nuc    [MAX_CENTERS];
    logic [5:0]         orb_reg;
    logic [4:0]         ctr_reg;
    pop_result_t        expected_q [$];

    function automatic logic signed [RES_W-1:0] sat48(input logic signed [79:0] v);
        if (v > 80'sh7FFF_FFFF_FFFF) return {1'b0, {(RES_W-1){1'b1}}};
        if (v < -80'sh8000_0000_0000) return {1'b1, {(RES_W-1){1'b0}}};
        return v[RES_W-1:0];
    endfunction

    // Gross population of orbital i: exact sum of products, round to Q24.24, saturate.
    function automatic logic signed [RES_W-1:0] gross_pop(input bit use_beta,
                                                           input int i, input int n);
        logic signed [79:0] acc;
        logic signed [63:0] prod;
        int hi, lo, ix;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            hi = (i >= k) ? i : k;
            lo = (i >= k) ? k : i;
            ix = hi * (hi + 1) / 2 + lo;
            prod = 64'(use_beta ? dens_b[ix] : dens_a[ix]) * 64'(ovlp[ix]);
            acc += 80'(prod);
        end
        return sat48((acc + 80'sd8388608) >>> 24);
    endfunction

    // Queue the whole result stream of one run.
    task automatic predict_run();
        logic signed [RES_W-1:0] net [MAX_CENTERS];
        logic signed [RES_W-1:0] pa, pb;
        pop_result_t r;
        int n, c;
        n = (orb_reg < 1) ? 1 : (orb_reg > MAX_ORBITALS) ? MAX_ORBITALS : orb_reg;
        c = (ctr_reg < 1) ? 1 : (ctr_reg > MAX_CENTERS) ? MAX_CENTERS : ctr_reg;
        for (int j = 0; j < c; j++) net[j] = RES_W'(nuc[j]);
        for (int i = 0; i < n; i++) begin
            pa = gross_pop(1'b0, i, n);
            pb = gross_pop(1'b1, i, n);
            if (owner[i] < c) begin
                net[owner[i]] = sat48(80'(net[owner[i]]) - 80'(pa));
                net[owner[i]] = sat48(80'(net[owner[i]]) - 80'(pb));
            end
            r = '{1'b0, 5'(i), pa, pb, 1'b0};
            expected_q.push_back(r);
        end
        for (int j = 0; j < c; j++) begin
            r = '{1'b1, 5'(j), net[j], '0, (j + 1 == c)};
            expected_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        pop_result_t e;
        if (!aresetn) begin
            orb_reg    = 6'd32;
            ctr_reg    = 5'd16;
            fail_count = 0;
            expected_q.delete();
            pending    = 0;
        end else begin
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NUM_ORBITALS) orb_reg = cfg_data;
                else ctr_reg = cfg_data[4:0];
            end
            // Apply input transfers
            if (s_valid && s_ready) begin
                case (s_kind)
                    KIND_ALPHA:  if (s_index < TRI_DEPTH) dens_a[s_index] = s_value;
                    KIND_BETA:   if (s_index < TRI_DEPTH) dens_b[s_index] = s_value;
                    KIND_OVLP:   if (s_index < TRI_DEPTH) ovlp[s_index] = s_value;
                    KIND_ORBCTR: if (s_index < MAX_ORBITALS) owner[s_index] = s_center_index;
                    KIND_CHARGE: if (s_index < MAX_CENTERS) nuc[s_index] = s_value;
                    KIND_RUN:    predict_run();
                    default: ;
                endcase
            end
            // Compare result transfers
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: unexpected result kind=%0d idx=%0d a=%0d b=%0d",
                                 m_result_kind, m_item_index, m_alpha_value, m_beta_value);
                end else begin
                    e = expected_q.pop_front();
                    if (e.rkind !== m_result_kind || e.idx !== m_item_index ||
                        e.a !== m_alpha_value || e.b !== m_beta_value ||
                        e.last !== m_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("checker: mismatch exp k=%0d i=%0d a=%0d b=%0d l=%0d %s",
                                     e.rkind, e.idx, e.a, e.b, e.last, "");
                        if (fail_count <= 10)
                            $display("checker:          got k=%0d i=%0d a=%0d b=%0d l=%0d",
                                     m_result_kind, m_item_index, m_alpha_value,
                                     m_beta_value, m_last);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the Mulliken population block: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb_top;
    import mpc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [2:0]              s_kind         = '0;
    logic [9:0]              s_index        = '0;
    logic signed [31:0]      s_value        = '0;
    logic [3:0]              s_center_index = '0;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_index      = 1'b0;
    logic [5:0]              cfg_data       = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic                    m_result_kind;
    logic [4:0]              m_item_index;
    logic signed [RES_W-1:0] m_alpha_value;
    logic signed [RES_W-1:0] m_beta_value;
    logic                    m_last;
    int                      fail_count;
    int                      pending;

    int  send_pct  = 14;
    int  recv_pct  = 84;
    int  items_out = 0;
    int  cycles    = 0;
    int  orb_eff   = 32;
    int  ctr_eff   = 16;
    bit  have_a [TRI_DEPTH];
    bit  have_b [TRI_DEPTH];
    bit  have_s [TRI_DEPTH];
    bit  have_o [MAX_ORBITALS];
    bit  have_c [MAX_CENTERS];

    mulliken_population_charges_top dut (.*);

    mpc_checker u_checker (.*);

    always #1 aclk = ~aclk;

    // Receiver stalls at random
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_pct);

    // Give up if the run hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One input transfer; idle gaps and the idling phase come first
    task automatic push_item(input logic [2:0] k, input logic [9:0] ix,
                             input logic [31:0] v, input logic [3:0] ci);
        bit ok;
        send_pct = (items_out < 140) ? 14 : (items_out < 280) ? 84 : 0;
        recv_pct = (items_out < 140) ? 84 : (items_out < 280) ? 14 : 0;
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= k;
        s_index        <= ix;
        s_value        <= v;
        s_center_index <= ci;
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
        items_out++;
        case (k)
            KIND_ALPHA:  if (ix < TRI_DEPTH) have_a[ix] = 1'b1;
            KIND_BETA:   if (ix < TRI_DEPTH) have_b[ix] = 1'b1;
            KIND_OVLP:   if (ix < TRI_DEPTH) have_s[ix] = 1'b1;
            KIND_ORBCTR: if (ix < MAX_ORBITALS) have_o[ix] = 1'b1;
            KIND_CHARGE: if (ix < MAX_CENTERS) have_c[ix] = 1'b1;
            default: ;
        endcase
    endtask

    // Hold off until every expected result has arrived and the block is idle
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [5:0] v);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
        if (r == REG_NUM_ORBITALS)
            orb_eff = (v < 1) ? 1 : (v > MAX_ORBITALS) ? MAX_ORBITALS : v;
        else
            ctr_eff = (v[4:0] < 1) ? 1 : (v[4:0] > MAX_CENTERS) ? MAX_CENTERS : v[4:0];
        @(posedge aclk);
    endtask

    task automatic set_sizes(input logic [5:0] orbs, input logic [5:0] ctrs);
        wait_drained();
        write_reg(REG_NUM_ORBITALS, orbs);
        write_reg(REG_NUM_CENTERS, ctrs);
    endtask

    // Load every entry a run will read that was never written, then run
    task automatic fill_and_run();
        for (int j = 0; j < orb_eff * (orb_eff + 1) / 2; j++) begin
            if (!have_a[j]) push_item(KIND_ALPHA, 10'(j), pick_value(), 4'($urandom));
            if (!have_b[j]) push_item(KIND_BETA, 10'(j), pick_value(), 4'($urandom));
            if (!have_s[j]) push_item(KIND_OVLP, 10'(j), pick_value(), 4'($urandom));
        end
        for (int j = 0; j < orb_eff; j++)
            if (!have_o[j]) push_item(KIND_ORBCTR, 10'(j), $urandom, 4'($urandom));
        for (int j = 0; j < ctr_eff; j++)
            if (!have_c[j]) push_item(KIND_CHARGE, 10'(j), pick_value(), 4'($urandom));
        push_item(KIND_RUN, 10'($urandom), $urandom, 4'($urandom));
    endtask

    initial begin
        int          r;
        logic [5:0]  orbs, ctrs;
        logic [2:0]  k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single orbital with extreme values
        set_sizes(6'd1, 6'd1);
        push_item(KIND_ALPHA, 10'd0, 32'h7FFF_FFFF, 4'd0);
        push_item(KIND_BETA, 10'd0, 32'h8000_0000, 4'd0);
        push_item(KIND_OVLP, 10'd0, 32'h8000_0000, 4'd0);
        push_item(KIND_ORBCTR, 10'd0, 32'h0, 4'd0);
        push_item(KIND_CHARGE, 10'd0, 32'h7FFF_FFFF, 4'd0);
        push_item(KIND_RUN, 10'd0, 32'h0, 4'd0);
        // Ignored: unknown kinds and out-of-range loads
        push_item(3'd6, 10'h3FF, 32'hFFFF_FFFF, 4'hF);
        push_item(3'd7, 10'h0, 32'h0, 4'h0);
        push_item(KIND_ALPHA, 10'h3FF, 32'h1234_5678, 4'h0);
        push_item(KIND_ORBCTR, 10'd32, 32'h0, 4'hF);
        push_item(KIND_CHARGE, 10'd16, 32'h7FFF_FFFF, 4'h0);
        // Orbital owned by a center not in use
        push_item(KIND_ALPHA, 10'd1, 32'h8000_0000, 4'd0);
        push_item(KIND_ALPHA, 10'd2, 32'h8000_0000, 4'd0);
        push_item(KIND_OVLP, 10'd1, 32'h8000_0000, 4'd0);
        push_item(KIND_OVLP, 10'd2, 32'h8000_0000, 4'd0);
        push_item(KIND_BETA, 10'd1, 32'h7FFF_FFFF, 4'd0);
        push_item(KIND_BETA, 10'd2, 32'h8000_0000, 4'd0);
        push_item(KIND_ORBCTR, 10'd1, 32'h0, 4'hF);
        push_item(KIND_CHARGE, 10'd0, 32'h8000_0000, 4'd0);
        set_sizes(6'd2, 6'd0);
        fill_and_run();
        set_sizes(6'd0, 6'd63);
        fill_and_run();

        // Random: size changes, reloads with random content, some noise
        while (items_out < 380) begin
            r = $urandom_range(99);
            if (r < 40) begin
                r = $urandom_range(99);
                if (r < 85)      orbs = 6'($urandom_range(1, 6));
                else if (r < 97) orbs = 6'($urandom_range(7, 8));
                else             orbs = 6'd0;
                r = $urandom_range(99);
                ctrs = (r < 85) ? 6'($urandom_range(1, 16)) : 6'($urandom);
                set_sizes(orbs, ctrs);
            end
            repeat ($urandom_range(8)) begin
                k = 3'($urandom_range(4));
                r = $urandom_range(99);
                if (r < 8)
                    push_item(3'($urandom_range(6, 7)), 10'($urandom), $urandom,
                              4'($urandom));
                else if (r < 16)
                    push_item(k, 10'($urandom_range(528, 1023)), $urandom, 4'($urandom));
                else if (k == KIND_ORBCTR)
                    push_item(k, 10'($urandom_range(orb_eff - 1)), $urandom, 4'($urandom));
                else if (k == KIND_CHARGE)
                    push_item(k, 10'($urandom_range(ctr_eff - 1)), pick_value(),
                              4'($urandom));
                else
                    push_item(k, 10'($urandom_range(orb_eff * (orb_eff + 1) / 2 - 1)),
                              pick_value(), 4'($urandom));
            end
            fill_and_run();
        end

        wait_drained();
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
